>>> rtl/multi_waveform_test_signal_generator_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the multi-waveform test signal generator
// Short wrappers for clocked assertions with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef MULTI_WAVEFORM_TEST_SIGNAL_GENERATOR_MACROS_SVH
`define MULTI_WAVEFORM_TEST_SIGNAL_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MWTSG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MWTSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/mwtsg_pkg.sv
// ---------------------------------------------------------------------------
// mwtsg_pkg
// Shared constants, register codes and sine table helpers for the
// multi-waveform test signal generator.
// ---------------------------------------------------------------------------
package mwtsg_pkg;

   // Default parameter values.
   localparam int SINE_TABLE_DEPTH_DEFAULT     = 1024;
   localparam int OUTPUT_FRACTION_BITS_DEFAULT = 16;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_WAVEFORM_SELECT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_INCREMENT = 1'd1;

   // Waveform codes; every other code plays the sine.
   localparam int WAVE_SEL_W = 3;
   localparam logic [WAVE_SEL_W-1:0] WAVE_SINE     = 3'd0;
   localparam logic [WAVE_SEL_W-1:0] WAVE_TRIANGLE = 3'd1;
   localparam logic [WAVE_SEL_W-1:0] WAVE_RAMP     = 3'd2;
   localparam logic [WAVE_SEL_W-1:0] WAVE_SQUARE   = 3'd3;

   localparam logic [31:0] PHASE_INC_RESET = 32'd42950000;

   // Phase, 2^32 is one cycle; the square wave uses one extra bit.
   localparam int PHASE_W = 33;
   localparam logic [PHASE_W-1:0] PHASE_HALF = 33'h0_8000_0000;

   // Level and slope, 2^31 is 1.0.
   localparam int LEVEL_W = 34;
   localparam logic signed [LEVEL_W:0]   LEVEL_ONE_WIDE       = 35'sh0_8000_0000;
   localparam logic signed [LEVEL_W:0]   LEVEL_MINUS_ONE_WIDE = -35'sh0_8000_0000;
   localparam logic signed [LEVEL_W-1:0] LEVEL_MINUS_ONE      = -34'sh0_8000_0000;
   localparam int LEVEL_FRACTION_BITS = 31;

   // pi/2 in Q28 and the Taylor series divisors (2k)(2k+1).
   localparam longint HALF_PI_Q28 = 64'sd421657428;
   localparam longint TAYLOR_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

   // Sine of x (Q28 radians, 0 to pi/2) rounded to frac fraction bits.
   function automatic longint sine_entry(input longint x, input int frac);
      longint x2;
      longint term;
      longint sum;
      int     sh;
      x2   = (x * x) >>> 28;
      term = x;
      sum  = x;
      for (int k = 1; k <= 8; k++) begin
         term = (term * x2) >>> 28;
         term = term / TAYLOR_DIV[k-1];
         if ((k % 2) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (frac < 28) begin
         sh  = 28 - frac;
         sum = (sum + (64'sd1 <<< (sh - 1))) >>> sh;
      end else begin
         sh  = frac - 28;
         sum = sum <<< sh;
      end
      return sum;
   endfunction

endpackage

>>> rtl/mwtsg_ram.sv
// ---------------------------------------------------------------------------
// mwtsg_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module mwtsg_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is enabled.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/multi_waveform_test_signal_generator.sv
// ---------------------------------------------------------------------------
// multi_waveform_test_signal_generator
// Direct digital synthesis source of sine, triangle, ramp and square samples.
// ---------------------------------------------------------------------------
// Usage
// Each beat on the req_ channel is one sample tick; req_restart clears the
// phase, level, slope and started flag before that tick is worked. Each tick
// gives exactly one beat on the rsp_ channel carrying a signed sample with
// OUTPUT_FRACTION_BITS fraction bits (1 << OUTPUT_FRACTION_BITS is 1.0).
// The csr_ port writes the waveform select (index 0) and the phase increment
// (index 1) whenever csr_wr_en is high; write only while the block is idle.
// The state update and sine table read happen in the first stage, the sign
// and output selection in the second. One tick is accepted every cycle once
// the table is loaded and while no receiver stall fills both stages; the
// phase and level accumulators each close their loop around their own register.
// After reset the quarter-wave sine table (SINE_TABLE_DEPTH + 1 entries) is
// loaded into its RAM, one entry a cycle, and req_ready stays low until the
// last entry is written. When the receiver stalls, the response register
// and the stage before it hold their beats and req_ready drops once both
// are full.
// ---------------------------------------------------------------------------
`include "multi_waveform_test_signal_generator_macros.svh"

module multi_waveform_test_signal_generator #(
   parameter int SINE_TABLE_DEPTH     = mwtsg_pkg::SINE_TABLE_DEPTH_DEFAULT,
   parameter int OUTPUT_FRACTION_BITS = mwtsg_pkg::OUTPUT_FRACTION_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_restart,
   // Response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [OUTPUT_FRACTION_BITS+1:0] rsp_sample_out,
   // Configuration port
   input  logic                                  csr_wr_en,
   input  logic [mwtsg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mwtsg_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import mwtsg_pkg::*;

   localparam int OUT_W       = OUTPUT_FRACTION_BITS + 2;
   localparam int TABLE_DEPTH = SINE_TABLE_DEPTH + 1;
   localparam int AW          = $clog2(TABLE_DEPTH);
   localparam int PROD_W      = 30 + AW;
   localparam int LEVEL_SHIFT = LEVEL_FRACTION_BITS - OUTPUT_FRACTION_BITS;

   localparam logic [AW-1:0] TABLE_LAST = AW'(SINE_TABLE_DEPTH);
   localparam logic signed [OUT_W-1:0] SAMPLE_ONE = OUT_W'(1) << OUTPUT_FRACTION_BITS;
   localparam logic signed [LEVEL_W-1:0] SAT_HI = (34'sd1 <<< (OUT_W - 1)) - 34'sd1;
   localparam logic signed [LEVEL_W-1:0] SAT_LO = -(34'sd1 <<< (OUT_W - 1));

   // Quarter-wave sine table, worked out at elaboration.
   typedef logic [OUT_W-1:0] sine_lut_type [TABLE_DEPTH];

   function automatic sine_lut_type build_sine_lut();
      sine_lut_type lut;
      longint       x;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x      = (HALF_PI_Q28 * longint'(i)) / SINE_TABLE_DEPTH;
         lut[i] = OUT_W'(sine_entry(x, OUTPUT_FRACTION_BITS));
      end
      return lut;
   endfunction

   localparam sine_lut_type SINE_LUT = build_sine_lut();

   // Floor of the level in output units, saturated to the output range.
   function automatic logic signed [OUT_W-1:0] level_to_sample(
      input logic signed [LEVEL_W-1:0] lvl
   );
      logic signed [LEVEL_W-1:0] shifted;
      shifted = lvl >>> LEVEL_SHIFT;
      if (shifted > SAT_HI) begin
         return SAT_HI[OUT_W-1:0];
      end else if (shifted < SAT_LO) begin
         return SAT_LO[OUT_W-1:0];
      end
      return shifted[OUT_W-1:0];
   endfunction

   // Configuration registers.
   logic [WAVE_SEL_W-1:0] waveform_select_ff;
   logic [31:0]           phase_increment_ff;

   // Generator state.
   logic [PHASE_W-1:0]        phase_ff, phase_in;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic signed [LEVEL_W-1:0] slope_ff, slope_in;
   logic                      started_ff, started_in;

   // Table load sweep.
   logic          fill_busy_ff;
   logic [AW-1:0] fill_cnt_ff;

   // First stage and response register.
   logic                     s1_valid_ff;
   logic                     s1_is_sine_ff, s1_is_sine_in;
   logic                     s1_negate_ff, s1_negate_in;
   logic signed [OUT_W-1:0]  s1_sample_ff, s1_sample_in;
   logic                     rsp_valid_ff;
   logic signed [OUT_W-1:0]  rsp_sample_ff, rsp_sample_in;

   // Handshake.
   logic req_accept;
   logic s1_move;

   // Sine table RAM.
   logic [AW-1:0]    ram_rd_addr;
   logic [OUT_W-1:0] ram_rd_data;

   // Working values of the current tick.
   logic [PHASE_W-1:0]        ph_cur;
   logic signed [LEVEL_W-1:0] lvl_cur, slp_cur, slp_neg;
   logic                      st_cur;
   logic [PROD_W-1:0]         addr_prod;
   logic [AW-1:0]             addr_raw;
   logic [PHASE_W-1:0]        phase_sum;
   logic signed [LEVEL_W:0]   sum_pos, sum_neg;
   logic                      flip_up, flip_down, use_neg;

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !fill_busy_ff && (!s1_valid_ff || s1_move);
   assign req_accept = req_valid && req_ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         waveform_select_ff <= WAVE_SINE;
         phase_increment_ff <= PHASE_INC_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WAVEFORM_SELECT: waveform_select_ff <= csr_wdata[WAVE_SEL_W-1:0];
            CSR_PHASE_INCREMENT: phase_increment_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Table load after reset: one entry a cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_busy_ff <= 1'b1;
         fill_cnt_ff  <= '0;
      end else if (fill_busy_ff) begin
         fill_cnt_ff <= fill_cnt_ff + AW'(1);
         if (fill_cnt_ff == TABLE_LAST) begin
            fill_busy_ff <= 1'b0;
         end
      end
   end

   // State as seen by this tick, after any restart.
   assign ph_cur  = req_restart ? '0 : phase_ff;
   assign lvl_cur = req_restart ? '0 : level_ff;
   assign slp_cur = req_restart ? '0 : slope_ff;
   assign st_cur  = req_restart ? 1'b0 : started_ff;

   // Sine table address from the phase within the quadrant.
   assign addr_prod   = PROD_W'(ph_cur[29:0]) * PROD_W'(SINE_TABLE_DEPTH);
   assign addr_raw    = addr_prod[PROD_W-1:30];
   assign ram_rd_addr = ph_cur[30] ? (TABLE_LAST - addr_raw) : addr_raw;

   assign phase_sum = ph_cur + {1'b0, phase_increment_ff};

   // Triangle: both candidate sums at once, then pick the slope direction.
   assign slp_neg   = -slp_cur;
   assign sum_pos   = {lvl_cur[LEVEL_W-1], lvl_cur} + {slp_cur[LEVEL_W-1], slp_cur};
   assign sum_neg   = {lvl_cur[LEVEL_W-1], lvl_cur} + {slp_neg[LEVEL_W-1], slp_neg};
   assign flip_up   = !slp_cur[LEVEL_W-1] && (sum_pos > LEVEL_ONE_WIDE);
   assign flip_down = (flip_up ? slp_neg[LEVEL_W-1] : slp_cur[LEVEL_W-1])
                      && ((flip_up ? sum_neg : sum_pos) < LEVEL_MINUS_ONE_WIDE);
   assign use_neg   = flip_up ^ flip_down;

   // Next state and first-stage result per waveform.
   always_comb begin
      phase_in      = ph_cur;
      level_in      = lvl_cur;
      slope_in      = slp_cur;
      started_in    = st_cur;
      s1_is_sine_in = 1'b0;
      s1_negate_in  = ph_cur[31];
      s1_sample_in  = '0;
      case (waveform_select_ff)
         WAVE_TRIANGLE: begin
            started_in = 1'b1;
            if (!st_cur) begin
               slope_in     = {1'b0, phase_increment_ff, 1'b0};
               level_in     = '0;
               s1_sample_in = '0;
            end else begin
               slope_in     = use_neg ? slp_neg : slp_cur;
               level_in     = use_neg ? sum_neg[LEVEL_W-1:0] : sum_pos[LEVEL_W-1:0];
               s1_sample_in = level_to_sample(level_in);
            end
         end
         WAVE_RAMP: begin
            started_in = 1'b1;
            if (!st_cur) begin
               slope_in = {2'b00, phase_increment_ff};
               level_in = LEVEL_MINUS_ONE;
            end else if (sum_pos > LEVEL_ONE_WIDE) begin
               level_in = LEVEL_MINUS_ONE;
            end else begin
               level_in = sum_pos[LEVEL_W-1:0];
            end
            s1_sample_in = level_to_sample(level_in);
         end
         WAVE_SQUARE: begin
            if (ph_cur <= PHASE_HALF) begin
               s1_sample_in = SAMPLE_ONE;
               phase_in     = phase_sum;
            end else if (!ph_cur[32]) begin
               s1_sample_in = -SAMPLE_ONE;
               phase_in     = phase_sum;
            end else begin
               s1_sample_in = SAMPLE_ONE;
               phase_in     = '0;
            end
         end
         default: begin
            s1_is_sine_in = 1'b1;
            phase_in      = {1'b0, ph_cur[31:0] + phase_increment_ff};
         end
      endcase
   end

   // Generator state update on each accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         level_ff   <= '0;
         slope_ff   <= '0;
         started_ff <= 1'b0;
      end else if (req_accept) begin
         phase_ff   <= phase_in;
         level_ff   <= level_in;
         slope_ff   <= slope_in;
         started_ff <= started_in;
      end
   end

   // First stage: valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // First stage: payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_is_sine_ff <= s1_is_sine_in;
         s1_negate_ff  <= s1_negate_in;
         s1_sample_ff  <= s1_sample_in;
      end
   end

   // Sine table, loaded after reset and read once per accepted beat.
   mwtsg_ram #(
      .WIDTH (OUT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_sine_ram (
      .clock   (clock),
      .wr_en   (fill_busy_ff),
      .wr_addr (fill_cnt_ff),
      .wr_data (SINE_LUT[fill_cnt_ff]),
      .rd_en   (req_accept),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Second stage: apply the quadrant sign to the table value for the sine, else pass the first-stage sample.
   always_comb begin
      if (s1_is_sine_ff) begin
         rsp_sample_in = s1_negate_ff ? -$signed(ram_rd_data) : $signed(ram_rd_data);
      end else begin
         rsp_sample_in = s1_sample_ff;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // Assertions.
   `MWTSG_ASSERT_SAME(a_table_addr_in_range, clock, reset, req_accept, (ram_rd_addr <= TABLE_LAST), "sine table read beyond its last entry")
   `MWTSG_ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_accept, s1_valid_ff, "accepted beat did not reach the first stage")
   `MWTSG_ASSERT_NEXT(a_sine_phase_wraps, clock, reset, (req_accept && s1_is_sine_in), (!phase_ff[32]), "sine phase left the 32-bit cycle")
   `MWTSG_ASSERT_NEXT(a_fill_ends, clock, reset, (fill_busy_ff && (fill_cnt_ff == TABLE_LAST)), (!fill_busy_ff), "table load did not finish after its last entry")

endmodule

>>> verif/multi_waveform_test_signal_generator_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// multi_waveform_test_signal_generator_tb
// Drives sample ticks into the generator under random sender and receiver
// stalls, predicts every sample in fixed point and compares each returned
// beat with the oldest prediction. Covers all four waveform shapes, the
// spare select codes, restart, mode changes without restart and extreme
// phase increments.
// ---------------------------------------------------------------------------

// Predicts the sample for every accepted tick and checks returned samples.
class waveform_scoreboard;

   localparam int     DEPTH   = mwtsg_pkg::SINE_TABLE_DEPTH_DEFAULT;
   localparam int     FRAC    = mwtsg_pkg::OUTPUT_FRACTION_BITS_DEFAULT;
   localparam int     OUT_W   = FRAC + 2;
   localparam longint ONE_Q31 = 64'sd1 <<< 31;
   localparam longint HALF_PI = 64'sd421657428;

   longint                  quarter_wave [0:DEPTH];
   logic [2:0]              wave_sel;
   logic [31:0]             phase_inc;
   logic [32:0]             phase;
   longint                  level;
   longint                  slope;
   bit                      started;
   logic signed [OUT_W-1:0] sample_q [$];
   int                      mismatches;
   int                      compared;
   int                      ticks_by_wave [4];

   function new();
      longint x;
      longint x2;
      longint term;
      longint acc;
      // Quarter-wave table: Taylor series of sin in Q28, rounded to FRAC bits.
      for (int i = 0; i <= DEPTH; i++) begin
         x    = (HALF_PI * i) / DEPTH;
         x2   = (x * x) >>> 28;
         term = x;
         acc  = x;
         for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >>> 28) / longint'((2 * k) * (2 * k + 1));
            acc  = (k % 2 == 1) ? acc - term : acc + term;
         end
         if (acc < 0) begin
            acc = 0;
         end
         quarter_wave[i] = (acc + (64'sd1 <<< (27 - FRAC))) >>> (28 - FRAC);
      end
      wave_sel      = mwtsg_pkg::WAVE_SINE;
      phase_inc     = mwtsg_pkg::PHASE_INC_RESET;
      mismatches    = 0;
      compared      = 0;
      ticks_by_wave = '{default: 0};
      clear_state();
   endfunction

   function void clear_state();
      phase   = '0;
      level   = 0;
      slope   = 0;
      started = 1'b0;
   endfunction

   // Level and slope live in a 34-bit signed register.
   function longint wrap34(longint v);
      logic signed [33:0] w;
      w = v[33:0];
      return longint'(w);
   endfunction

   // Floor from the Q31 level down to the output format, then saturate.
   function longint level_to_sample(longint lv);
      longint r;
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (OUT_W - 1)) - 1;
      lo = -(64'sd1 <<< (OUT_W - 1));
      r  = lv >>> (31 - FRAC);
      if (r > hi) begin
         r = hi;
      end
      if (r < lo) begin
         r = lo;
      end
      return r;
   endfunction

   function void set_register(logic [mwtsg_pkg::CSR_INDEX_W-1:0] idx, logic [31:0] data);
      if (idx == mwtsg_pkg::CSR_WAVEFORM_SELECT) begin
         wave_sel = data[2:0];
      end else begin
         phase_inc = data;
      end
   endfunction

   function int pending();
      return sample_q.size();
   endfunction

   // One accepted tick: advance the predicted state and queue its sample.
   function void note_tick(bit restart);
      longint      s;
      longint      v;
      longint      one;
      logic [31:0] ph32;
      int          addr;
      one = 64'sd1 <<< FRAC;
      if (restart) begin
         clear_state();
      end
      case (wave_sel)
         mwtsg_pkg::WAVE_TRIANGLE: begin
            ticks_by_wave[mwtsg_pkg::WAVE_TRIANGLE]++;
            if (!started) begin
               started = 1'b1;
               slope   = wrap34(2 * longint'(phase_inc));
               level   = 0;
               s       = 0;
            end else begin
               v = level + slope;
               // Reverse on passing +1, and again if that passes -1.
               if (slope >= 0 && v > ONE_Q31) begin
                  slope = wrap34(-slope);
                  v     = level + slope;
               end
               if (slope < 0 && v < -ONE_Q31) begin
                  slope = wrap34(-slope);
                  v     = level + slope;
               end
               level = wrap34(v);
               s     = level_to_sample(level);
            end
         end
         mwtsg_pkg::WAVE_RAMP: begin
            ticks_by_wave[mwtsg_pkg::WAVE_RAMP]++;
            if (!started) begin
               started = 1'b1;
               slope   = longint'(phase_inc);
               level   = -ONE_Q31;
            end else begin
               v = level + slope;
               if (v > ONE_Q31) begin
                  v = -ONE_Q31;
               end
               level = wrap34(v);
            end
            s = level_to_sample(level);
         end
         mwtsg_pkg::WAVE_SQUARE: begin
            ticks_by_wave[mwtsg_pkg::WAVE_SQUARE]++;
            // The square keeps the 33rd phase bit to spot the end of a cycle.
            if (phase <= mwtsg_pkg::PHASE_HALF) begin
               s     = one;
               phase = phase + phase_inc;
            end else if (!phase[32]) begin
               s     = -one;
               phase = phase + phase_inc;
            end else begin
               s     = one;
               phase = '0;
            end
         end
         default: begin
            ticks_by_wave[mwtsg_pkg::WAVE_SINE]++;
            ph32 = phase[31:0];
            addr = int'((longint'(ph32[29:0]) * DEPTH) >>> 30);
            if (addr > DEPTH) begin
               addr = DEPTH;
            end
            s = ph32[30] ? quarter_wave[DEPTH - addr] : quarter_wave[addr];
            if (ph32[31]) begin
               s = -s;
            end
            phase = {1'b0, ph32 + phase_inc};
         end
      endcase
      sample_q.push_back(s[OUT_W-1:0]);
   endfunction

   task report(string msg);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   task check_sample(logic signed [OUT_W-1:0] got);
      logic signed [OUT_W-1:0] want;
      if (sample_q.size() == 0) begin
         report($sformatf("sample %0d arrived with none outstanding", got));
      end else begin
         want = sample_q.pop_front();
         compared++;
         if (got !== want) begin
            report($sformatf("sample_out %0d, predicted %0d", got, want));
         end
      end
   endtask

endclass

module multi_waveform_test_signal_generator_tb;

   import mwtsg_pkg::*;

   // Select codes with no shape of their own; they play the sine.
   localparam logic [WAVE_SEL_W-1:0] WAVE_SPARE_FIRST = 3'd4;
   localparam logic [WAVE_SEL_W-1:0] WAVE_SPARE_LAST  = 3'd7;
   localparam int RANDOM_TICKS = 600;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_ready;
   logic                    req_restart = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready   = 1'b0;
   logic signed [17:0]      rsp_sample_out;
   logic                    csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata   = '0;

   waveform_scoreboard sb;
   bit                 stalls_on = 1'b1;
   int                 ticks_sent = 0;
   int                 settings_used = 0;

   multi_waveform_test_signal_generator u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly no gap, sometimes a few cycles, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(15, 40);
   endfunction

   // Note every accepted tick and check every returned beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_tick(req_restart);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_sample(rsp_sample_out);
         end
      end
   end

   // Receiver: runs of ready broken by random stalls while stalls are on.
   initial begin
      int busy;
      int idle;
      wait (!reset);
      forever begin
         busy = $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (busy) @(posedge clock);
         if (stalls_on) begin
            idle = pick_gap();
            if (idle > 0) begin
               rsp_ready <= 1'b0;
               repeat (idle) @(posedge clock);
            end
         end
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      sb.set_register(idx, data);
   endtask

   // One tick beat; valid stays high into the next beat when there is no gap.
   task automatic send_tick(input bit restart, input int gap);
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Every sample returned, plus a short settle for the two-stage pipeline.
   task automatic wait_idle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Program a setting, send a burst of ticks and let the block drain.
   task automatic run_phase(input logic [WAVE_SEL_W-1:0] wave, input logic [31:0] inc,
                            input int n_ticks, input logic [7:0] restart_mask,
                            input int restart_pct);
      bit restart;
      int gap;
      write_csr(CSR_WAVEFORM_SELECT, {29'd0, wave});
      write_csr(CSR_PHASE_INCREMENT, inc);
      settings_used++;
      for (int i = 0; i < n_ticks; i++) begin
         restart = ((i < 8) && restart_mask[i]) || ($urandom_range(0, 99) < restart_pct);
         gap     = pick_gap();
         if (i == n_ticks - 1 && gap == 0) begin
            gap = 1;
         end
         send_tick(restart, gap);
      end
      wait_idle();
   endtask

   initial begin
      logic [WAVE_SEL_W-1:0] wave;
      logic [31:0]           inc;
      int                    r;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Sine through all four quadrants.
      run_phase(WAVE_SINE, 32'h4000_0000, 4, 8'b0000_0001, 0);
      // Triangle at the half-scale increment: double reversal and saturation.
      run_phase(WAVE_TRIANGLE, 32'h8000_0000, 4, 8'b0000_0001, 0);
      // Ramp held at -1 by a zero increment, then wrapping past +1.
      run_phase(WAVE_RAMP, 32'h0000_0000, 2, 8'b0000_0001, 0);
      run_phase(WAVE_RAMP, 32'h8000_0000, 4, 8'b0000_0001, 0);
      // Square with an oversized increment reaches the end-of-cycle case.
      run_phase(WAVE_SQUARE, 32'hFFFF_FFFF, 3, 8'b0000_0001, 0);
      // Square leaves the phase above one cycle; a spare code then plays
      // the sine from its low 32 bits.
      run_phase(WAVE_SQUARE, 32'h6000_0000, 3, 8'b0000_0001, 0);
      run_phase(WAVE_SPARE_FIRST, 32'h6000_0000, 2, 8'b0000_0000, 0);
      // Triangle with the full-scale increment gives the largest slope, which still fits without wrapping.
      run_phase(WAVE_TRIANGLE, 32'hFFFF_FFFF, 3, 8'b0000_0001, 0);

      // Random settings; no restart between phases carries state over.
      while (ticks_sent < RANDOM_TICKS + 25) begin
         r = $urandom_range(0, 9);
         case (r)
            0, 1:    wave = WAVE_SINE;
            2, 3:    wave = WAVE_TRIANGLE;
            4, 5:    wave = WAVE_RAMP;
            6, 7:    wave = WAVE_SQUARE;
            default: wave = WAVE_SEL_W'($urandom_range(WAVE_SPARE_FIRST, WAVE_SPARE_LAST));
         endcase
         r = $urandom_range(0, 9);
         if (r == 0) begin
            case ($urandom_range(0, 3))
               0:       inc = 32'h0000_0000;
               1:       inc = 32'h0000_0001;
               2:       inc = 32'h8000_0000;
               default: inc = 32'hFFFF_FFFF;
            endcase
         end else if (r < 5) begin
            inc = $urandom_range(32'h0010_0000, 32'h0800_0000);
         end else if (r < 8) begin
            inc = $urandom_range(32'h0800_0000, 32'h8000_0000);
         end else begin
            inc = $urandom();
         end
         stalls_on = ($urandom_range(0, 3) != 0);
         run_phase(wave, inc, $urandom_range(10, 50), {7'd0, 1'($urandom_range(0, 1))}, 3);
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d samples never returned", sb.pending()));
      end
      $display("Covered %0d ticks over %0d settings: sine %0d, triangle %0d, ramp %0d, square %0d.",
               ticks_sent, settings_used, sb.ticks_by_wave[WAVE_SINE],
               sb.ticks_by_wave[WAVE_TRIANGLE], sb.ticks_by_wave[WAVE_RAMP],
               sb.ticks_by_wave[WAVE_SQUARE]);
      $display("Compared %0d samples, %0d mismatches.", sb.compared, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("multi_waveform_test_signal_generator test passed");
      end else begin
         $display("multi_waveform_test_signal_generator test failed");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("multi_waveform_test_signal_generator test failed");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/mwtsg_pkg.sv
rtl/mwtsg_ram.sv
rtl/multi_waveform_test_signal_generator.sv
verif/multi_waveform_test_signal_generator_tb.sv
